FILE: hdl/sobel_et_pkg.sv
// Shared types and constants for the Sobel edge threshold block.
// Holds the request, response and window column beat types, and the CSR and pixel codes.
// No dependencies; the sobel_edge_threshold top level imports it.
`timescale 1ns / 1ps

package sobel_et_pkg;

   // CSR port geometry and register indexes
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_EDGE_THRESHOLD = 2'd2;

   // reset values of the registers
   localparam logic [CSR_DATA_W-1:0] SIZE_RESET   = 11'd1024;
   localparam logic [CSR_DATA_W-1:0] THRESH_RESET = 11'd128;

   // item kinds and result codes
   localparam logic       ACTION_PIXEL = 1'b0;
   localparam logic       ACTION_DRAIN = 1'b1;
   localparam logic [7:0] PIX_EDGE     = 8'd0;
   localparam logic [7:0] PIX_FLAT     = 8'd255;

   // arithmetic widths: weighted column sum, signed gradient, squared magnitude
   localparam int SUM_W  = 10;
   localparam int GRAD_W = 11;
   localparam int MAG_W  = 2 * CSR_DATA_W;

   typedef struct packed {
      logic       action;
      logic [7:0] pixel;
   } req_data_type;

   typedef struct packed {
      logic [7:0] out_pixel;
      logic [9:0] col;
      logic [9:0] row;
      logic       frame_end;
   } rsp_data_type;

   // one window column: upper, middle and lower row sample
   typedef struct packed {
      logic [7:0] up;
      logic [7:0] mid;
      logic [7:0] down;
   } pix_col_type;

endpackage

FILE: hdl/sobel_edge_threshold.sv
// Sobel 3x3 edge threshold over a raster pixel stream, two row stores, border clamping.
// Throughput: one item per cycle unless stalled; each row store is a one-port-write,
// one-port-read memory. The item completing a window passes stages A, B and C to the
// output register; in items, results trail the input by frame width + 1.
// Reset (synchronous, active high) loads width 1024, height 1024, threshold 128 and
// restarts the frame; row store contents are undefined until written.
`timescale 1ns / 1ps

module sobel_edge_threshold #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  sobel_et_pkg::req_data_type               req_data,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output sobel_et_pkg::rsp_data_type               rsp_data,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [sobel_et_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [sobel_et_pkg::CSR_DATA_W-1:0]      csr_data
);
   import sobel_et_pkg::*;

   localparam int W_W   = $clog2(MAX_WIDTH + 1);
   localparam int H_W   = $clog2(MAX_HEIGHT + 1);
   localparam int AW    = $clog2(MAX_WIDTH);
   localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int POS_W = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 1);

   // per-result position info carried down the pipe
   typedef struct packed {
      logic          left;
      logic          right;
      logic          last;
      logic [AW-1:0] out_col;
      logic [RW-1:0] out_row;
   } res_meta_type;

   typedef struct packed {
      logic          drain;
      logic [7:0]    pixel;
      logic [AW-1:0] col_addr;
      logic          row_zero;
      logic          row_one;
      logic          has_res;
      res_meta_type  meta;
   } a_item_type;

   // clamp a size register value to 1..maximum
   function automatic logic [W_W-1:0] clamp_width(input logic [CSR_DATA_W-1:0] v);
      if (v == '0) begin
         return W_W'(1);
      end else if (int'(v) > MAX_WIDTH) begin
         return W_W'(MAX_WIDTH);
      end else begin
         return W_W'(v);
      end
   endfunction

   function automatic logic [H_W-1:0] clamp_height(input logic [CSR_DATA_W-1:0] v);
      if (v == '0) begin
         return H_W'(1);
      end else if (int'(v) > MAX_HEIGHT) begin
         return H_W'(MAX_HEIGHT);
      end else begin
         return H_W'(v);
      end
   endfunction

   // configuration and derived frame geometry
   logic [W_W-1:0]   w_ff;
   logic [H_W-1:0]   h_ff;
   logic [POS_W-1:0] total_ff;
   logic [MAG_W-1:0] thr_lim_ff;
   logic             thr_zero_ff;

   // input side counters
   logic [POS_W-1:0] pos_ff;
   logic [AW-1:0]    in_col_ff;
   logic [1:0]       in_row_ff;
   logic [AW-1:0]    out_col_ff;
   logic [RW-1:0]    out_row_ff;

   // row stores and read path
   logic [7:0]  upper_mem [MAX_WIDTH];
   logic [7:0]  middle_mem [MAX_WIDTH];
   logic [7:0]  up_rd_ff;
   logic [7:0]  mid_rd_ff;
   logic        hit_ff;
   logic [7:0]  fwd_mid_ff;
   logic [7:0]  fwd_down_ff;

   // pipeline stages
   logic         a_valid_ff;
   a_item_type   a_item_ff;
   logic         b_valid_ff;
   res_meta_type b_meta_ff;
   pix_col_type  win_ff [3];
   logic                     c_valid_ff;
   logic signed [GRAD_W-1:0] gx_ff;
   logic signed [GRAD_W-1:0] gy_ff;
   res_meta_type             c_meta_ff;
   logic         rsp_valid_ff;
   rsp_data_type rsp_data_ff;

   // combinational
   logic             csr_we;
   logic [W_W-1:0]   csr_w;
   logic [H_W-1:0]   csr_h;
   logic [AW-1:0]    wm1;
   logic [RW-1:0]    hm1;
   logic [POS_W-1:0] wp1;
   logic [POS_W-1:0] pos_end;
   logic             is_drain;
   logic             ignore_beat;
   logic             has_res;
   logic             out_left;
   logic             out_right;
   logic             out_last;
   logic             front_take;
   logic             push;
   logic             rsp_ready;
   logic             c_adv;
   logic             c_ready;
   logic             b_adv;
   logic             b_ready;
   logic             a_adv;
   logic             a_we;
   logic [7:0]       up_rd;
   logic [7:0]       mid_rd;
   pix_col_type      new_col;
   pix_col_type      col_l;
   pix_col_type      col_c;
   pix_col_type      col_r;
   logic [SUM_W-1:0] sum_l;
   logic [SUM_W-1:0] sum_r;
   logic [SUM_W-1:0] sum_t;
   logic [SUM_W-1:0] sum_b;
   logic signed [GRAD_W-1:0]   gx;
   logic signed [GRAD_W-1:0]   gy;
   logic signed [2*GRAD_W-1:0] gx_sq;
   logic signed [2*GRAD_W-1:0] gy_sq;
   logic [MAG_W-1:0]           mag_sq;
   logic                       is_edge;

   // geometry helpers
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;
   assign csr_w     = clamp_width(csr_data);
   assign csr_h     = clamp_height(csr_data);
   assign wm1       = AW'(w_ff - W_W'(1));
   assign hm1       = RW'(h_ff - H_W'(1));
   assign wp1       = POS_W'(w_ff) + POS_W'(1);
   assign pos_end   = total_ff + POS_W'(w_ff);

   // classify the incoming beat
   assign is_drain    = pos_ff >= total_ff;
   assign ignore_beat = !is_drain && (req_data.action == ACTION_DRAIN);
   assign has_res     = pos_ff >= wp1;
   assign out_left    = out_col_ff == '0;
   assign out_right   = out_col_ff == wm1;
   assign out_last    = out_right && (out_row_ff == hm1);

   // pipeline flow control, output side first
   assign rsp_ready  = !rsp_valid_ff || !rsp_stall;
   assign c_adv      = c_valid_ff && rsp_ready;
   assign c_ready    = !c_valid_ff || c_adv;
   assign b_adv      = b_valid_ff && c_ready;
   assign b_ready    = !b_valid_ff || b_adv;
   assign a_adv      = a_valid_ff && b_ready;
   assign req_stall  = a_valid_ff && !a_adv;
   assign front_take = req_valid && !req_stall;
   assign push       = front_take && !ignore_beat;
   assign a_we       = a_adv && !a_item_ff.drain;

   // configuration registers and frame counters
   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff        <= clamp_width(SIZE_RESET);
         h_ff        <= clamp_height(SIZE_RESET);
         total_ff    <= POS_W'(clamp_width(SIZE_RESET)) * POS_W'(clamp_height(SIZE_RESET));
         thr_lim_ff  <= MAG_W'(THRESH_RESET) * MAG_W'(THRESH_RESET) - MAG_W'(THRESH_RESET);
         thr_zero_ff <= 1'b0;
         pos_ff      <= '0;
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH: begin
               w_ff     <= csr_w;
               total_ff <= POS_W'(csr_w) * POS_W'(h_ff);
            end
            CSR_FRAME_HEIGHT: begin
               h_ff     <= csr_h;
               total_ff <= POS_W'(w_ff) * POS_W'(csr_h);
            end
            CSR_EDGE_THRESHOLD: begin
               thr_lim_ff  <= MAG_W'(csr_data) * MAG_W'(csr_data) - MAG_W'(csr_data);
               thr_zero_ff <= csr_data == '0;
            end
            default: begin
            end
         endcase
         // any known register restarts the frame
         if (csr_index == CSR_FRAME_WIDTH || csr_index == CSR_FRAME_HEIGHT ||
             csr_index == CSR_EDGE_THRESHOLD) begin
            pos_ff     <= '0;
            in_col_ff  <= '0;
            in_row_ff  <= '0;
            out_col_ff <= '0;
            out_row_ff <= '0;
         end
      end else if (push) begin
         if (has_res && out_last) begin
            // last result of the frame: start over
            pos_ff     <= '0;
            in_col_ff  <= '0;
            in_row_ff  <= '0;
            out_col_ff <= '0;
            out_row_ff <= '0;
         end else begin
            pos_ff <= pos_ff + POS_W'(1);
            if (in_col_ff == wm1) begin
               in_col_ff <= '0;
               if (in_row_ff != 2'd2) begin
                  in_row_ff <= in_row_ff + 2'd1;
               end
            end else begin
               in_col_ff <= in_col_ff + AW'(1);
            end
            if (has_res) begin
               if (out_right) begin
                  out_col_ff <= '0;
                  out_row_ff <= out_row_ff + RW'(1);
               end else begin
                  out_col_ff <= out_col_ff + AW'(1);
               end
            end
         end
      end
   end

   // stage A: capture the beat and read both row stores
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (push) begin
         a_valid_ff <= 1'b1;
      end else if (a_adv) begin
         a_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         a_item_ff.drain        <= is_drain;
         a_item_ff.pixel        <= req_data.pixel;
         a_item_ff.col_addr     <= in_col_ff;
         a_item_ff.row_zero     <= in_row_ff == 2'd0;
         a_item_ff.row_one      <= in_row_ff == 2'd1;
         a_item_ff.has_res      <= has_res;
         a_item_ff.meta.left    <= out_left;
         a_item_ff.meta.right   <= out_right;
         a_item_ff.meta.last    <= out_last;
         a_item_ff.meta.out_col <= out_col_ff;
         a_item_ff.meta.out_row <= out_row_ff;
         up_rd_ff               <= upper_mem[in_col_ff];
         mid_rd_ff              <= middle_mem[in_col_ff];
         // same column being written at this edge: take the new data
         hit_ff                 <= a_we && (a_item_ff.col_addr == in_col_ff);
      end
   end

   // write the row stores as a pixel beat leaves stage A
   always_ff @(posedge clock) begin
      if (a_we) begin
         upper_mem[a_item_ff.col_addr]  <= new_col.mid;
         middle_mem[a_item_ff.col_addr] <= new_col.down;
         fwd_mid_ff                     <= new_col.mid;
         fwd_down_ff                    <= new_col.down;
      end
   end

   // build the new window column: top border clamping, bottom row copied on drains
   assign up_rd  = hit_ff ? fwd_mid_ff : up_rd_ff;
   assign mid_rd = hit_ff ? fwd_down_ff : mid_rd_ff;

   always_comb begin
      if (!a_item_ff.drain) begin
         new_col.down = a_item_ff.pixel;
         if (a_item_ff.row_zero) begin
            new_col.mid = a_item_ff.pixel;
            new_col.up  = a_item_ff.pixel;
         end else begin
            new_col.mid = mid_rd;
            new_col.up  = a_item_ff.row_one ? mid_rd : up_rd;
         end
      end else begin
         new_col.mid  = mid_rd;
         new_col.down = mid_rd;
         new_col.up   = (a_item_ff.row_zero || a_item_ff.row_one) ? mid_rd : up_rd;
      end
   end

   // stage B: shift the window
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (a_adv) begin
         b_valid_ff <= a_item_ff.has_res;
      end else if (b_adv) begin
         b_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (a_adv) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= win_ff[2];
         win_ff[2] <= new_col;
         b_meta_ff <= a_item_ff.meta;
      end
   end

   // gradients with left and right border clamping
   assign col_c = win_ff[1];
   assign col_l = b_meta_ff.left ? win_ff[1] : win_ff[0];
   assign col_r = b_meta_ff.right ? win_ff[1] : win_ff[2];

   assign sum_l = SUM_W'(col_l.up) + {1'b0, col_l.mid, 1'b0} + SUM_W'(col_l.down);
   assign sum_r = SUM_W'(col_r.up) + {1'b0, col_r.mid, 1'b0} + SUM_W'(col_r.down);
   assign sum_t = SUM_W'(col_l.up) + {1'b0, col_c.up, 1'b0} + SUM_W'(col_r.up);
   assign sum_b = SUM_W'(col_l.down) + {1'b0, col_c.down, 1'b0} + SUM_W'(col_r.down);
   assign gx    = $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
   assign gy    = $signed({1'b0, sum_b}) - $signed({1'b0, sum_t});

   // stage C: hold the gradients
   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (b_adv) begin
         c_valid_ff <= 1'b1;
      end else if (c_adv) begin
         c_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (b_adv) begin
         gx_ff     <= gx;
         gy_ff     <= gy;
         c_meta_ff <= b_meta_ff;
      end
   end

   // squared magnitude against T*T-T, i.e. rounded magnitude >= T
   assign gx_sq   = gx_ff * gx_ff;
   assign gy_sq   = gy_ff * gy_ff;
   assign mag_sq  = $unsigned(gx_sq) + $unsigned(gy_sq);
   assign is_edge = thr_zero_ff || (mag_sq > thr_lim_ff);

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (c_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (c_adv) begin
         rsp_data_ff.out_pixel <= is_edge ? PIX_EDGE : PIX_FLAT;
         rsp_data_ff.col       <= 10'(c_meta_ff.out_col);
         rsp_data_ff.row       <= 10'(c_meta_ff.out_row);
         rsp_data_ff.frame_end <= c_meta_ff.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   // column counters stay inside the frame width
   assert property (@(posedge clock) disable iff (reset)
      (in_col_ff <= wm1) && (out_col_ff <= wm1))
      else $error("column counter beyond frame width");

   // stream position never passes the last flush beat
   assert property (@(posedge clock) disable iff (reset)
      pos_ff <= pos_end)
      else $error("stream position beyond frame end");

   // a blocked stage A keeps its beat
   assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && !a_adv) |=> (a_valid_ff && $stable(a_item_ff)))
      else $error("stage A lost its beat while blocked");
`endif

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for sobel_edge_threshold: raster frames, drain beats and CSR writes.
// Predicts every edge result in-house and checks each rsp beat in order as it is taken.
// Depends on sobel_et_pkg and the sobel_edge_threshold RTL.
`timescale 1ns / 1ps

module tb_top;
   import sobel_et_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;
   localparam int LINE_MAX      = 1024;
   localparam int ROW_MAX       = 1024;
   localparam int SETTLE_CYCLES = 16;
   localparam int RANDOM_ITEMS  = 80;
   localparam int GAP_PCT       = 23;

   typedef enum int {PAT_NOISE, PAT_BINARY, PAT_RAMP, PAT_SOFT} pattern_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_data_type           req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_data_type           rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   // register copies and stream state of the edge predictor
   logic [CSR_DATA_W-1:0] width_reg  = SIZE_RESET;
   logic [CSR_DATA_W-1:0] height_reg = SIZE_RESET;
   logic [CSR_DATA_W-1:0] thresh_reg = THRESH_RESET;
   logic [7:0]            older_line [LINE_MAX] = '{default: '0};
   logic [7:0]            last_line  [LINE_MAX] = '{default: '0};
   int                    taps [3][3];   // [column: left, center, right][row: up, mid, down]
   int unsigned           stream_idx, wr_col, wr_row, rd_col, rd_row;

   rsp_data_type exp_edges [$];
   int unsigned  items_used   = 0;
   int           mismatches   = 0;
   bit           send_gaps    = 1'b0;
   bit           recv_gaps    = 1'b0;
   int           hold_request = 0;
   int           hold_left    = 0;

   sobel_edge_threshold dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   function automatic int unsigned clamp_size(logic [CSR_DATA_W-1:0] v, int unsigned top);
      if (v == 0) return 1;
      if (v > top) return top;
      return v;
   endfunction

   task automatic restart_stream();
      taps       = '{default: 0};
      stream_idx = 0;
      wr_col     = 0;
      wr_row     = 0;
      rd_col     = 0;
      rd_row     = 0;
   endtask

   // advance the predictor by one accepted beat, queue the result it yields
   task automatic predict_sobel(input req_data_type d);
      int unsigned  w, h;
      bit           drain, frame_done;
      int           up, mid, down, li, ri, gx, gy;
      longint       mag2, t;
      rsp_data_type r;
      w     = clamp_size(width_reg, LINE_MAX);
      h     = clamp_size(height_reg, ROW_MAX);
      drain = stream_idx >= w * h;
      // drop a drain that comes before the frame's pixels are complete
      if (!drain && d.action == ACTION_DRAIN) return;
      items_used++;
      if (!drain) begin
         down = d.pixel;
         if (wr_row == 0) begin
            up  = down;
            mid = down;
         end else begin
            mid = last_line[wr_col];
            up  = (wr_row == 1) ? mid : older_line[wr_col];
         end
         older_line[wr_col] = 8'(mid);
         last_line[wr_col]  = d.pixel;
      end else begin
         // replicate the bottom row while flushing
         mid  = last_line[wr_col];
         up   = (wr_row <= 1) ? mid : older_line[wr_col];
         down = mid;
      end
      taps[0] = taps[1];
      taps[1] = taps[2];
      taps[2] = '{up, mid, down};

      if (stream_idx >= w + 1) begin
         // clamp left and right columns at the frame border
         li   = (rd_col == 0) ? 1 : 0;
         ri   = (rd_col == w - 1) ? 1 : 2;
         gx   = taps[ri][0] + 2 * taps[ri][1] + taps[ri][2]
              - taps[li][0] - 2 * taps[li][1] - taps[li][2];
         gy   = taps[li][2] + 2 * taps[1][2] + taps[ri][2]
              - taps[li][0] - 2 * taps[1][0] - taps[ri][0];
         mag2 = longint'(gx) * gx + longint'(gy) * gy;
         t    = thresh_reg;
         frame_done  = (rd_col == w - 1) && (rd_row == h - 1);
         r.out_pixel = (t == 0 || mag2 > t * t - t) ? PIX_EDGE : PIX_FLAT;
         r.col       = 10'(rd_col);
         r.row       = 10'(rd_row);
         r.frame_end = frame_done;
         exp_edges   = {exp_edges, r};
         if (frame_done) begin
            restart_stream();
            return;
         end
         rd_col++;
         if (rd_col >= w) begin
            rd_col = 0;
            rd_row++;
         end
      end
      stream_idx++;
      wr_col++;
      if (wr_col >= w) begin
         wr_col = 0;
         wr_row++;
      end
   endtask

   // compare each taken rsp beat with the oldest predicted edge result
   always @(posedge clock) begin
      rsp_data_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (exp_edges.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: out_pixel %0d col %0d row %0d frame_end %b",
                        rsp_data.out_pixel, rsp_data.col, rsp_data.row, rsp_data.frame_end);
         end else begin
            want = exp_edges.pop_front();
            if (rsp_data.out_pixel !== want.out_pixel || rsp_data.col !== want.col ||
                rsp_data.row !== want.row || rsp_data.frame_end !== want.frame_end) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp pix %0d col %0d row %0d end %b, got %0d %0d %0d %b",
                           want.out_pixel, want.col, want.row, want.frame_end,
                           rsp_data.out_pixel, rsp_data.col, rsp_data.row, rsp_data.frame_end);
            end
         end
      end
   end

   // result side: long hold-offs on request, random stalls otherwise if recv_gaps is set
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= recv_gaps && ($urandom_range(99) < GAP_PCT);
      end
   end

   // offer one beat, hold it until taken, then predict it
   task automatic send_beat(input logic act, input logic [7:0] pix);
      req_data_type d;
      d.action = act;
      d.pixel  = pix;
      while (send_gaps && $urandom_range(99) < GAP_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= d;
      do @(posedge clock); while (req_stall);
      predict_sobel(d);
   endtask

   // stop offering and wait until every predicted result has come back
   task automatic settle();
      req_valid <= 1'b0;
      while (exp_edges.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // leaves csr_valid high so writes can run back to back
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_FRAME_WIDTH: begin
            width_reg = val;
            restart_stream();
         end
         CSR_FRAME_HEIGHT: begin
            height_reg = val;
            restart_stream();
         end
         CSR_EDGE_THRESHOLD: begin
            thresh_reg = val;
            restart_stream();
         end
         default: ;
      endcase
   endtask

   task automatic write_config(input logic [CSR_DATA_W-1:0] w, h, t);
      csr_write(CSR_FRAME_WIDTH, w);
      csr_write(CSR_FRAME_HEIGHT, h);
      csr_write(CSR_EDGE_THRESHOLD, t);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] pick_pixel(pattern_type pat, int unsigned c, int unsigned r);
      case (pat)
         PAT_BINARY: return $urandom_range(1) ? 8'hFF : 8'h00;
         PAT_RAMP:   return 8'(c * 23 + r * 41);
         PAT_SOFT:   return 8'(120 + $urandom_range(15));
         default:    return 8'($urandom_range(255));
      endcase
   endfunction

   // one whole frame plus its flush; early_pct adds ignored drains, fake_pct
   // sends pixel beats where the flush only needs drains
   task automatic send_frame(input int unsigned w, h, input pattern_type pat,
                             input int early_pct, fake_pct);
      for (int unsigned r = 0; r < h; r++) begin
         for (int unsigned c = 0; c < w; c++) begin
            if ($urandom_range(99) < early_pct)
               send_beat(ACTION_DRAIN, 8'($urandom_range(255)));
            send_beat(ACTION_PIXEL, pick_pixel(pat, c, r));
         end
      end
      for (int unsigned k = 0; k <= w; k++)
         send_beat(($urandom_range(99) < fake_pct) ? ACTION_PIXEL : ACTION_DRAIN,
                   8'($urandom_range(255)));
   endtask

   // threshold keeps its reset value; only the frame size is set
   task automatic test_reset_threshold();
      csr_write(CSR_FRAME_WIDTH, 11'd5);
      csr_write(CSR_FRAME_HEIGHT, 11'd3);
      csr_valid <= 1'b0;
      send_frame(5, 3, PAT_BINARY, 0, 0);
      settle();
   endtask

   task automatic test_threshold_extremes();
      // zero threshold marks every pixel, the top one marks none
      write_config(11'd3, 11'd2, 11'd0);
      send_frame(3, 2, PAT_NOISE, 0, 0);
      settle();
      write_config(11'd3, 11'd2, 11'd2047);
      send_frame(3, 2, PAT_BINARY, 0, 0);
      settle();
      write_config(11'd4, 11'd2, 11'd1);
      send_frame(4, 2, PAT_SOFT, 0, 0);
      settle();
   endtask

   task automatic test_drain_rules();
      write_config(11'd4, 11'd2, 11'd60);
      send_frame(4, 2, PAT_RAMP, 30, 50);
      // extra drains land at the head of the next frame and are dropped
      repeat (2) send_beat(ACTION_DRAIN, 8'($urandom_range(255)));
      send_frame(4, 2, PAT_BINARY, 0, 0);
      settle();
   endtask

   task automatic test_restart();
      write_config(11'd6, 11'd3, 11'd90);
      // fewer than width+1 beats: nothing comes out yet
      repeat (5) send_beat(ACTION_PIXEL, 8'($urandom_range(255)));
      settle();
      csr_write(CSR_EDGE_THRESHOLD, 11'd40);
      csr_valid <= 1'b0;
      repeat (10) send_beat(ACTION_PIXEL, 8'($urandom_range(255)));
      settle();
      // the spare index changes nothing, so the frame carries on
      csr_write(CSR_SPARE, 11'($urandom_range(2047)));
      csr_valid <= 1'b0;
      repeat (8) send_beat(ACTION_PIXEL, 8'($urandom_range(255)));
      repeat (7) send_beat(ACTION_DRAIN, 8'($urandom_range(255)));
      settle();
   endtask

   task automatic test_size_clamp();
      // a zero height counts as one row
      write_config(11'd7, 11'd0, 11'd300);
      send_frame(7, 1, PAT_NOISE, 2, 10);
      settle();
      // zero width counts as one, a height above the maximum as the maximum;
      // this long frame runs with no idling on either side
      send_gaps = 1'b0;
      recv_gaps = 1'b0;
      write_config(11'd0, 11'd2047, 11'd5);
      send_frame(1, 1024, PAT_BINARY, 2, 10);
      settle();
      send_gaps = 1'b1;
      recv_gaps = 1'b1;
   endtask

   // hold the result side long enough to fill the block and stall its input
   task automatic test_backpressure();
      write_config(11'd8, 11'd6, 11'd100);
      send_gaps    = 1'b0;
      hold_request = 300;
      send_frame(8, 6, PAT_NOISE, 0, 0);
      settle();
      send_gaps = 1'b1;
   endtask

   task automatic test_random_frames();
      int unsigned start, w_raw, h_raw, t_raw, w, h, cut;
      bit          fresh;
      pattern_type pat;
      start     = items_used;
      fresh     = 1'b1;
      send_gaps = 1'b1;
      recv_gaps = 1'b1;
      while (items_used - start < RANDOM_ITEMS) begin
         if (fresh || $urandom_range(99) < 65) begin
            settle();
            w_raw = ($urandom_range(99) < 85) ? $urandom_range(1, 12) : $urandom_range(13, 48);
            if ($urandom_range(99) < 5) w_raw = 0;
            h_raw = $urandom_range(0, 8);
            case ($urandom_range(9))
               0:       t_raw = 0;
               1:       t_raw = $urandom_range(2047);
               2, 3:    t_raw = $urandom_range(1, 40);
               default: t_raw = $urandom_range(40, 500);
            endcase
            write_config(11'(w_raw), 11'(h_raw), 11'(t_raw));
            fresh = 1'b0;
         end
         w   = clamp_size(width_reg, LINE_MAX);
         h   = clamp_size(height_reg, ROW_MAX);
         pat = pattern_type'($urandom_range(3));
         if ($urandom_range(99) < 8) begin
            // broken frame: stop partway and force a rewrite next pass
            cut = $urandom % (w * h);
            repeat (cut) send_beat(ACTION_PIXEL, 8'($urandom_range(255)));
            fresh = 1'b1;
         end else begin
            send_frame(w, h, pat, ($urandom_range(99) < 20) ? 5 : 0,
                       ($urandom_range(99) < 25) ? 30 : 0);
            if ($urandom_range(99) < 15)
               repeat ($urandom_range(1, 2)) send_beat(ACTION_DRAIN, 8'($urandom_range(255)));
         end
      end
      settle();
   endtask

   initial begin
      restart_stream();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_gaps = 1'b1;
      recv_gaps = 1'b1;
      test_reset_threshold();
      test_threshold_extremes();
      test_drain_rules();
      test_restart();
      test_size_clamp();
      test_backpressure();
      test_random_frames();
      settle();
      if (mismatches == 0) $display("sobel_edge_threshold regression: pass");
      else $display("sobel_edge_threshold regression: fail");
      $finish;
   end

   // hard stop if the handshakes hang
   initial begin
      #5_000_000;
      $display("sobel_edge_threshold regression: fail");
      $finish;
   end

endmodule
